// File: rtl/sie_pkg.sv
`default_nettype none
package sie_pkg;
	localparam int NumRegs = 32;
	localparam int RegIdxW = 5;
	localparam int PcW = 10;

	localparam logic [1:0] TypeR = 2'd0;
	localparam logic [1:0] TypeI = 2'd1;
	localparam logic [1:0] TypeJ = 2'd2;
	localparam logic [1:0] TypeP = 2'd3;

	localparam logic [3:0] OpAdd = 4'd0;
	localparam logic [3:0] OpSub = 4'd1;
	localparam logic [3:0] OpMul = 4'd2;
	localparam logic [3:0] OpDiv = 4'd3;
	localparam logic [3:0] OpMod = 4'd4;
	localparam logic [3:0] OpBeq = 4'd5;
	localparam logic [3:0] OpBne = 4'd6;
	localparam logic [3:0] OpMove = 4'd7;
	localparam logic [3:0] OpPrint = 4'd8;

	localparam logic [1:0] FaultNone = 2'd0;
	localparam logic [1:0] FaultDivZero = 2'd1;
	localparam logic [1:0] FaultBadOp = 2'd2;

	typedef struct packed {
		logic start;
		logic want_mod;
	} sie_div_ctl_t;
endpackage
`default_nettype wire

// File: rtl/small_isa_instruction_executor.sv
`default_nettype none
// Executes one instruction per request and returns one result per request.
// The 32 registers sit in a synchronous memory. src1 is read at the edge that
// accepts the request, and src2 or dest is read in StRdA and StRdB. StExec
// then executes and loads the result register, which offers the result.
// Div and mod with a nonzero divisor start the one-bit-per-cycle divider
// instead and offer their result when it is done. A new request is taken
// only once the previous result has been taken, at the earliest in the cycle
// after. Reset clears the registers with a sweep through all 32 of them,
// during which no request is taken.
module small_isa_instruction_executor (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [31:0] instruction_word,
	output logic out_valid,
	input wire logic out_ready,
	output logic [9:0] next_pc,
	output logic reg_written,
	output logic [4:0] write_index,
	output logic signed [31:0] write_value,
	output logic printed,
	output logic signed [31:0] print_value,
	output logic [1:0] fault
);
	typedef enum logic [5:0] {
		StClear = 6'b000001,
		StIdle = 6'b000010,
		StRdA = 6'b000100,
		StRdB = 6'b001000,
		StExec = 6'b010000,
		StDiv = 6'b100000
	} state_t;

	state_t state_q;
	logic [31:0] regs [sie_pkg::NumRegs];
	logic [31:0] rd_q, a_q, param_q, instr_q;
	logic [4:0] clr_q;
	logic [9:0] pc_q;
	logic mem_we;
	logic [4:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;

	logic [1:0] ityp;
	logic [3:0] iop;
	logic [4:0] idst, is2;
	logic [31:0] imm, b_val;
	assign ityp = instr_q[31:30];
	assign iop = instr_q[29:26];
	assign idst = instr_q[25:21];
	assign is2 = instr_q[15:11];
	assign imm = {16'd0, instr_q[15:0]};
	// From StRdB on, rd_q holds src2 for R-type arithmetic or dest for branches.
	assign b_val = (ityp == sie_pkg::TypeR) ? rd_q : imm;

	logic branch_op;
	assign branch_op = (iop == sie_pkg::OpBeq) || (iop == sie_pkg::OpBne);

	sie_pkg::sie_div_ctl_t div_ctl;
	logic div_done;
	logic [31:0] div_res;
	sie_divider u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .dividend(a_q), .divisor(b_val),
		.done(div_done), .result(div_res)
	);

	logic is_div;
	assign is_div = (ityp == sie_pkg::TypeR || ityp == sie_pkg::TypeI)
		&& (iop == sie_pkg::OpDiv || iop == sie_pkg::OpMod);
	assign div_ctl.start = (state_q == StExec) && is_div && (b_val != 32'd0);
	assign div_ctl.want_mod = (iop == sie_pkg::OpMod);

	// Execute result, valid in StExec (or at divider completion).
	logic ex_wr, ex_pr;
	logic [31:0] ex_val;
	logic [9:0] ex_pc;
	logic [1:0] ex_fault;
	always_comb begin
		ex_wr = 1'b0;
		ex_pr = 1'b0;
		ex_val = '0;
		ex_pc = pc_q + 10'd1;
		ex_fault = sie_pkg::FaultNone;
		case (ityp)
			sie_pkg::TypeJ: ex_pc = instr_q[9:0];
			sie_pkg::TypeP: begin
				ex_wr = 1'b1;
				ex_val = param_q;
			end
			default: begin
				case (iop)
					sie_pkg::OpAdd: begin ex_wr = 1'b1; ex_val = a_q + b_val; end
					sie_pkg::OpSub: begin ex_wr = 1'b1; ex_val = a_q - b_val; end
					sie_pkg::OpMul: begin ex_wr = 1'b1; ex_val = a_q * b_val; end
					sie_pkg::OpDiv, sie_pkg::OpMod: begin
						ex_wr = 1'b1;
						if (b_val == 32'd0) ex_fault = sie_pkg::FaultDivZero;
					end
					sie_pkg::OpBeq: if (a_q == rd_q) ex_pc = instr_q[9:0];
					sie_pkg::OpBne: if (a_q != rd_q) ex_pc = instr_q[9:0];
					sie_pkg::OpMove: begin ex_wr = 1'b1; ex_val = a_q; end
					sie_pkg::OpPrint: ex_pr = (ityp == sie_pkg::TypeR);
					default: ex_fault = sie_pkg::FaultBadOp;
				endcase
			end
		endcase
	end

	logic finish;
	assign finish = ((state_q == StExec) && !div_ctl.start) || (state_q == StDiv && div_done);
	logic [31:0] fin_val;
	assign fin_val = (state_q == StDiv) ? div_res : ex_val;

	assign in_ready = (state_q == StIdle) && !out_valid;

	// src1 is read as the request is accepted; afterwards the read port stays on
	// src2 or dest so that the second operand holds steady through a divide.
	always_comb begin
		if (state_q == StIdle) mem_ra = instruction_word[20:16];
		else mem_ra = (ityp == sie_pkg::TypeR && !branch_op) ? is2 : idst;
		if (state_q == StClear) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_we = finish && ex_wr;
			mem_wa = idst;
			mem_wd = fin_val;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) regs[mem_wa] <= mem_wd;
		rd_q <= regs[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) instr_q <= instruction_word;
		if (state_q == StRdA) a_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StClear;
			clr_q <= '0;
			pc_q <= '0;
			param_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) param_q <= cfg_wdata;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				StClear: begin
					clr_q <= clr_q + 5'd1;
					if (clr_q == 5'd31) state_q <= StIdle;
				end
				StIdle: if (in_valid && in_ready) state_q <= StRdA;
				StRdA: state_q <= StRdB;
				StRdB: state_q <= StExec;
				StExec: state_q <= div_ctl.start ? StDiv : StIdle;
				StDiv: if (div_done) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
			if (finish) begin
				out_valid <= 1'b1;
				pc_q <= ex_pc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			next_pc <= ex_pc;
			reg_written <= ex_wr;
			write_index <= ex_wr ? idst : 5'd0;
			write_value <= ex_wr ? fin_val : 32'd0;
			printed <= ex_pr;
			print_value <= ex_pr ? a_q : 32'd0;
			fault <= ex_fault;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) finish |=> out_valid)
		else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> !out_valid)
		else $error("request taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StClear |-> !in_ready)
		else $error("request taken during clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StDiv) |-> !(in_valid && in_ready))
		else $error("request taken during divide");
endmodule
`default_nettype wire

// File: rtl/sie_divider.sv
`default_nettype none
// Signed restoring divider, one quotient bit per cycle. The divisor is nonzero.
module sie_divider (
	input wire logic clk,
	input wire logic arst_n,
	input wire sie_pkg::sie_div_ctl_t ctl,
	input wire logic [31:0] dividend,
	input wire logic [31:0] divisor,
	output logic done,
	output logic [31:0] result
);
	logic [31:0] quo_q, rem_q, den_q;
	logic [5:0] cnt_q;
	logic busy_q, neg_q_q, neg_r_q, mod_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, quo_q[31]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend[31] ? 32'd0 - dividend : dividend;
			den_q <= divisor[31] ? 32'd0 - divisor : divisor;
			rem_q <= '0;
			neg_q_q <= dividend[31] ^ divisor[31];
			neg_r_q <= dividend[31];
			mod_q <= ctl.want_mod;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (mod_q) result = neg_r_q ? 32'd0 - rem_q : rem_q;
		else result = neg_q_q ? 32'd0 - quo_q : quo_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n) ctl.start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != 6'd0)
		else $error("divider count underflow");
endmodule
`default_nettype wire
